// ----- src/evh_pkg.sv -----
`default_nettype none

package evh_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SPEECH = 2'd1,
    MODE_HANG   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } event_t;

  localparam logic [2:0] REG_START_LEVEL    = 3'd0;
  localparam logic [2:0] REG_END_LEVEL      = 3'd1;
  localparam logic [2:0] REG_START_RUN      = 3'd2;
  localparam logic [2:0] REG_END_RUN        = 3'd3;
  localparam logic [2:0] REG_MIN_SPEECH_LEN = 3'd4;
  localparam logic [2:0] REG_MAX_SPEECH_LEN = 3'd5;

  localparam logic [15:0] START_LEVEL_RESET    = 16'd1000;
  localparam logic [15:0] END_LEVEL_RESET      = 16'd500;
  localparam logic [7:0]  START_RUN_RESET      = 8'd3;
  localparam logic [7:0]  END_RUN_RESET        = 8'd10;
  localparam logic [15:0] MIN_SPEECH_LEN_RESET = 16'd5;
  localparam logic [15:0] MAX_SPEECH_LEN_RESET = 16'd1000;

endpackage

`default_nettype wire

// ----- src/energy_vad_hangover_unit.sv -----
// Channel  | Valid     | Stall     | Payload
// request  | in_valid  | in_stall  | frame_level
// result   | out_valid | out_stall | vad_event, vad_mode
// config   | cfg_write | none      | cfg_index, cfg_data
//
// One request is taken every clock cycle unless the request side stalls, and its result appears in the cycle after.
// The detector state and the result register are updated at the cycle of acceptance.
// The request side stalls only while a result is held and the result side stalls.
// Synchronous reset returns the detector to idle and the registers to defaults.
`default_nettype none

module energy_vad_hangover_unit
  import evh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] frame_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       vad_event,
  output logic [1:0]       vad_mode,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] start_level;
  logic [15:0] end_level;
  logic [7:0]  start_run;
  logic [7:0]  end_run;
  logic [15:0] min_speech_len;
  logic [15:0] max_speech_len;

  mode_t       mode;
  mode_t       mode_next;
  logic [7:0]  loud_run;
  logic [7:0]  loud_run_next;
  logic [7:0]  quiet_run;
  logic [7:0]  quiet_run_next;
  logic [15:0] speech_len;
  logic [15:0] speech_len_next;
  event_t      ev;

  logic        accept;
  logic        loud;
  logic        quiet;
  logic [7:0]  loud_inc;
  logic [7:0]  quiet_inc;
  logic [15:0] len_inc;
  logic        started;
  logic        forced;
  logic        ended;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign loud      = frame_level >= start_level;
  assign quiet     = frame_level <= end_level;
  assign loud_inc  = (loud_run == 8'hFF) ? loud_run : loud_run + 8'd1;
  assign quiet_inc = (quiet_run == 8'hFF) ? quiet_run : quiet_run + 8'd1;
  assign len_inc   = (speech_len == 16'hFFFF) ? speech_len : speech_len + 16'd1;
  assign started   = loud && (loud_inc >= start_run);
  assign forced    = len_inc >= max_speech_len;
  assign ended     = quiet && (quiet_inc >= end_run);

  always_comb begin
    unique case (mode)
      MODE_IDLE: begin
        mode_next = started ? MODE_SPEECH : MODE_IDLE;
      end
      MODE_SPEECH: begin
        if (forced) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next = quiet ? MODE_HANG : MODE_SPEECH;
        end
      end
      MODE_HANG: begin
        priority if (forced || ended) begin
          mode_next = MODE_IDLE;
        end else if (quiet) begin
          mode_next = MODE_HANG;
        end else begin
          mode_next = MODE_SPEECH;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    ev              = EV_NONE;
    loud_run_next   = loud_run;
    quiet_run_next  = quiet_run;
    speech_len_next = speech_len;
    unique case (mode)
      MODE_IDLE: begin
        speech_len_next = '0;
        quiet_run_next  = '0;
        if (started) begin
          loud_run_next = '0;
          ev            = EV_START;
        end else begin
          loud_run_next = loud ? loud_inc : 8'd0;
        end
      end
      MODE_SPEECH, MODE_HANG: begin
        speech_len_next = len_inc;
        priority if (forced) begin
          loud_run_next  = '0;
          quiet_run_next = '0;
          ev             = EV_END;
        end else if (quiet) begin
          quiet_run_next = quiet_inc;
          if (mode == MODE_HANG && ended) begin
            if (len_inc >= min_speech_len) begin
              ev = EV_END;
            end
            loud_run_next   = '0;
            quiet_run_next  = '0;
            speech_len_next = '0;
          end
        end else begin
          quiet_run_next = '0;
        end
      end
      default: begin
        loud_run_next   = '0;
        quiet_run_next  = '0;
        speech_len_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level    <= START_LEVEL_RESET;
      end_level      <= END_LEVEL_RESET;
      start_run      <= START_RUN_RESET;
      end_run        <= END_RUN_RESET;
      min_speech_len <= MIN_SPEECH_LEN_RESET;
      max_speech_len <= MAX_SPEECH_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_LEVEL:    start_level    <= cfg_data;
        REG_END_LEVEL:      end_level      <= cfg_data;
        REG_START_RUN:      start_run      <= cfg_data[7:0];
        REG_END_RUN:        end_run        <= cfg_data[7:0];
        REG_MIN_SPEECH_LEN: min_speech_len <= cfg_data;
        REG_MAX_SPEECH_LEN: max_speech_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      loud_run   <= '0;
      quiet_run  <= '0;
      speech_len <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      loud_run   <= loud_run_next;
      quiet_run  <= quiet_run_next;
      speech_len <= speech_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vad_event <= ev;
      vad_mode  <= mode_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/evh_checker.sv -----
`default_nettype none

module evh_checker
  import evh_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] vad_event,
  input wire logic [1:0] vad_mode
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vad_event) && $stable(vad_mode))
    else $error("Stalled result changed.");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted request produced no result.");

  a_start_enters_speech: assert property (@(posedge clk) disable iff (rst)
    out_valid && vad_event == EV_START |-> vad_mode == MODE_SPEECH)
    else $error("Start event without speech mode.");

  a_end_enters_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && vad_event == EV_END |-> vad_mode == MODE_IDLE)
    else $error("End event without idle mode.");

endmodule

bind energy_vad_hangover_unit evh_checker u_evh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .vad_event (vad_event),
  .vad_mode  (vad_mode)
);

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;
  import evh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    event_t ev;
    mode_t  md;
  } decision_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] frame_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  vad_event;
  logic [1:0]  vad_mode;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_START_LEVEL;
  logic [15:0] cfg_data = '0;

  logic [15:0] levels_to_send[$];
  decision_t   expected_decisions[$];
  decision_t   oldest;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        long_hold = 1'b0;

  // Shadow copy of the detector registers and state.
  logic [15:0] lvl_start = START_LEVEL_RESET;
  logic [15:0] lvl_end = END_LEVEL_RESET;
  logic [7:0]  run_start = START_RUN_RESET;
  logic [7:0]  run_end = END_RUN_RESET;
  logic [15:0] len_min = MIN_SPEECH_LEN_RESET;
  logic [15:0] len_max = MAX_SPEECH_LEN_RESET;
  mode_t       p_mode = MODE_IDLE;
  logic [7:0]  p_loud = '0;
  logic [7:0]  p_quiet = '0;
  logic [15:0] p_len = '0;

  energy_vad_hangover_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_level(frame_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .vad_event(vad_event),
    .vad_mode(vad_mode),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void predict_decision(input logic [15:0] level);
    decision_t d;
    d.ev = EV_NONE;
    case (p_mode)
      MODE_IDLE: begin
        p_len = '0;
        p_quiet = '0;
        if (level >= lvl_start) begin
          if (p_loud != 8'hFF) p_loud = p_loud + 8'd1;
          if (p_loud >= run_start) begin
            p_mode = MODE_SPEECH;
            p_loud = '0;
            d.ev = EV_START;
          end
        end else begin
          p_loud = '0;
        end
      end
      MODE_SPEECH, MODE_HANG: begin
        if (p_len != 16'hFFFF) p_len = p_len + 16'd1;
        if (p_len >= len_max) begin
          p_mode = MODE_IDLE;
          p_loud = '0;
          p_quiet = '0;
          d.ev = EV_END;
        end else if (p_mode == MODE_SPEECH) begin
          if (level <= lvl_end) begin
            if (p_quiet != 8'hFF) p_quiet = p_quiet + 8'd1;
            p_mode = MODE_HANG;
          end else begin
            p_quiet = '0;
          end
        end else if (level <= lvl_end) begin
          if (p_quiet != 8'hFF) p_quiet = p_quiet + 8'd1;
          if (p_quiet >= run_end) begin
            if (p_len >= len_min) d.ev = EV_END;
            p_mode = MODE_IDLE;
            p_loud = '0;
            p_quiet = '0;
            p_len = '0;
          end
        end else begin
          p_mode = MODE_SPEECH;
          p_quiet = '0;
        end
      end
      default: begin
        p_mode = MODE_IDLE;
        p_loud = '0;
        p_quiet = '0;
        p_len = '0;
      end
    endcase
    d.md = p_mode;
    expected_decisions.push_back(d);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_decision(frame_level);
      if (!in_valid || !in_stall) begin
        if (levels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          frame_level <= levels_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_decisions.size() == 0) begin
        note_mismatch("result with no request pending");
      end else begin
        oldest = expected_decisions.pop_front();
        if (vad_event !== oldest.ev)
          note_mismatch($sformatf("vad_event %0d, wanted %0d", vad_event, oldest.ev));
        if (vad_mode !== oldest.md)
          note_mismatch($sformatf("vad_mode %0d, wanted %0d", vad_mode, oldest.md));
      end
    end
    if (rst) out_stall <= 1'b0;
    else if (long_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [15:0] loud_level();
    return 16'($urandom_range(65535, lvl_start));
  endfunction

  function automatic logic [15:0] quiet_level();
    return 16'($urandom_range(lvl_end, 0));
  endfunction

  function automatic logic [15:0] middle_level();
    if (int'(lvl_start) > int'(lvl_end) + 1)
      return 16'($urandom_range(int'(lvl_start) - 1, int'(lvl_end) + 1));
    return 16'($urandom);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_START_LEVEL:    lvl_start = data;
      REG_END_LEVEL:      lvl_end = data;
      REG_START_RUN:      run_start = data[7:0];
      REG_END_RUN:        run_end = data[7:0];
      REG_MIN_SPEECH_LEN: len_min = data;
      REG_MAX_SPEECH_LEN: len_max = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] sl, input logic [15:0] el, input logic [15:0] sr,
                           input logic [15:0] er, input logic [15:0] mn, input logic [15:0] mx);
    write_reg(REG_START_LEVEL, sl);
    write_reg(REG_END_LEVEL, el);
    write_reg(REG_START_RUN, sr);
    write_reg(REG_END_RUN, er);
    write_reg(REG_MIN_SPEECH_LEN, mn);
    write_reg(REG_MAX_SPEECH_LEN, mx);
    @(negedge clk);
  endtask

  // Mostly utterance-shaped runs around the configured thresholds, with some noise.
  task automatic queue_frames(input int budget);
    int n;
    int len;
    int brk;
    int i;
    n = 0;
    while (n < budget) begin
      case ($urandom_range(9))
        0: begin
          levels_to_send.push_back(16'($urandom));
          n++;
        end
        1, 2, 3: begin
          len = int'(run_start) - 1 + $urandom_range(2);
          if (len < 1) len = 1;
          for (i = 0; i < len; i++) levels_to_send.push_back(loud_level());
          n += len;
        end
        4, 5, 6: begin
          len = $urandom_range(8, 1);
          for (i = 0; i < len; i++) begin
            case ($urandom_range(2))
              0: levels_to_send.push_back(loud_level());
              1: levels_to_send.push_back(middle_level());
              default: levels_to_send.push_back(quiet_level());
            endcase
          end
          n += len;
        end
        default: begin
          len = int'(run_end) - 1 + $urandom_range(2);
          if (len < 1) len = 1;
          brk = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : -1;
          for (i = 0; i < len; i++)
            levels_to_send.push_back((i == brk) ? loud_level() : quiet_level());
          n += len;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (levels_to_send.size() != 0 || in_valid || expected_decisions.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [15:0] opening[20];
    logic [15:0] sl;
    int ph;
    opening = '{16'd0, 16'd65535, 16'd999, 16'd1000, 16'd1000, 16'd65535, 16'd500,
                16'd501, 16'h5555, 16'hAAAA, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 77;
    foreach (opening[i]) levels_to_send.push_back(opening[i]);
    queue_frames(60);
    wait_drained();

    // Zero runs and zero maximum length; only the low byte of a run register counts.
    write_all(16'd0, 16'd65535, 16'hAB00, 16'h5500, 16'd0, 16'd0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    queue_frames(60);
    wait_drained();

    // Widest thresholds and start run, with a long receiver hold-off while requests keep coming.
    write_all(16'd65535, 16'd0, 16'd255, 16'd1, 16'd65535, 16'd65535);
    queue_frames(150);
    long_hold = 1'b1;
    repeat (200) @(negedge clk);
    long_hold = 1'b0;
    wait_drained();

    send_idle_pct = 77;
    recv_idle_pct = 6;
    write_all(16'd20000, 16'd20000, 16'd1, 16'd255, 16'd300, 16'd65535);
    queue_frames(150);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sl = 16'($urandom_range(60000, 100));
      write_all(sl,
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(sl, 0)),
                16'($urandom_range(6, 1)), 16'($urandom_range(10, 1)),
                16'($urandom_range(30)),
                ($urandom_range(1) == 0) ? 16'($urandom_range(60, 5)) : 16'd1000);
      queue_frames(100);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[energy_vad_hangover_unit] OK");
    end else begin
      $display("[energy_vad_hangover_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[energy_vad_hangover_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
